### rtl/opi_pkg.sv
// Package for the ODE pair integrator: number format, limits, method codes,
// sequencer states and a fixed-point saturation helper. No dependencies.
package opi_pkg;

  localparam int FRAC_BITS = 24;
  localparam int MAX_STEPS = 4095;
  localparam int STEP_W    = 12;

  typedef logic signed [31:0] q_t;

  typedef enum logic [1:0] {
    METH_RK4  = 2'd0,
    METH_MID  = 2'd1,
    METH_EUL  = 2'd2,
    METH_EUL3 = 2'd3
  } method_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_G,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_STAGE,
    ST_ACC,
    ST_DIV,
    ST_UPD,
    ST_DONE
  } state_t;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  function automatic q_t sat36(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return Q_MAX;
    if (v < -36'sd2147483648) return Q_MIN;
    return v[31:0];
  endfunction

endpackage

### rtl/opi_if.sv
// Valid/ready channel interface carrying one word of payload.
// Depends on nothing; payload type is supplied per instance.
interface opi_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/opi_mulq.sv
// Shared Q-format multiplier: registered 32x32 product, then rounding and
// saturation done combinationally after the register. Depends on opi_pkg.
module opi_mulq
  import opi_pkg::*;
(
  input  logic clk,
  input  q_t   a,
  input  q_t   b,
  output q_t   p
);
  logic signed [63:0] prod;
  logic signed [63:0] rnd;
  logic signed [39:0] sh;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  always_comb begin
    rnd = prod + (64'sd1 <<< (FRAC_BITS - 1));
    sh  = 40'(rnd >>> FRAC_BITS);
    if (sh > 40'sd2147483647) p = Q_MAX;
    else if (sh < -40'sd2147483648) p = Q_MIN;
    else p = sh[31:0];
  end
endmodule

### rtl/ode_pair_integrator_top.sv
// ODE pair integrator: steps y' = z, z' = x + 2y - 3z from a start point
// with step h while x <= end_x, using fourth-order Runge-Kutta, midpoint or
// forward Euler (register method). One request gives one result word. All
// products go through one shared multiplier (result in the cycle after its
// operands) under a small sequencer. For each slope stage the sequencer forms
// g, then waits on the two products in turn; fourth-order Runge-Kutta then
// divides both weighted sums by six before the update. The step count is
// capped at 4095. The block takes no new word until the result word is
// taken.
// Depends on opi_pkg, opi_if and opi_mulq.
module ode_pair_integrator_top
  import opi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  opi_if.sink         in_ch,
  opi_if.source       out_ch
);
  // input word layout: start_x, start_y, start_z, step_size, end_x
  // output word layout: final_x, final_y, final_z, steps_capped

  method_t method;
  state_t  state, state_next;

  q_t x, y, z, xe, xr, h, hh;
  q_t ys, zs;            // stage point
  q_t gv;                // g at stage point
  q_t ky, kz;            // current stage slopes
  logic signed [35:0] sy, sz;
  logic [1:0] stage;     // 0..3
  logic [STEP_W-1:0] n;
  logic [1:0] wait_cnt;
  logic capped;

  q_t ma, mb, mp;
  opi_mulq u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  logic cont;
  assign cont = (x <= xe) && (n < STEP_W'(MAX_STEPS));

  // stage x: first stage at x, middle at x+h/2, last at x+h
  q_t xs;
  always_comb begin
    if (stage == 2'd0) xs = x;
    else if (stage == 2'd3) xs = sat36(36'(x) + 36'(h));
    else xs = xr;
  end

  // division by six with round half up: floor((s+3)/6), one sum at a time,
  // y sum first. Since 2^19 = 6*87381 + 2, n = nh*2^19 + nl splits into
  // 87381*nh + floor((2*nh + nl)/6); the small quotient comes from a
  // reciprocal multiply, then one remainder check fixes the last unit.
  localparam logic signed [36:0] DIV_HI  = 37'sd87381;
  localparam logic signed [43:0] DIV_RCP = 44'sd2796203;

  logic [2:0] div_cnt;
  logic signed [36:0] dn, dqa, dq, dr, dfix;
  logic signed [20:0] dm;
  logic signed [43:0] dprod;
  logic signed [35:0] dsel;

  always_comb begin
    dsel  = div_cnt[2] ? sz : sy;
    dprod = 44'(dm) * DIV_RCP;
    dr    = dn - dq * 37'sd6;
    if (dr < 0) dfix = dq - 37'sd1;
    else if (dr >= 37'sd6) dfix = dq + 37'sd1;
    else dfix = dq;
  end

  logic signed [35:0] dy, dz;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_ch.valid) state_next = ST_CHECK;
      ST_CHECK: state_next = cont ? ST_G : ST_DONE;
      ST_G:     state_next = ST_MUL_Y;
      ST_MUL_Y: if (wait_cnt == 2'd2) state_next = ST_MUL_Z;
      ST_MUL_Z: if (wait_cnt == 2'd2) state_next = ST_STAGE;
      ST_STAGE: begin
        if (method == METH_RK4 && stage != 2'd3) state_next = ST_G;
        else if (method == METH_MID && stage == 2'd0) state_next = ST_G;
        else if (method == METH_RK4) state_next = ST_DIV;
        else state_next = ST_UPD;
      end
      ST_DIV:   if (div_cnt == 3'd7) state_next = ST_UPD;
      ST_UPD:   state_next = ST_CHECK;
      ST_DONE:  if (out_ch.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = (state == ST_IDLE);
    out_ch.valid = (state == ST_DONE);
    out_ch.data  = {x, y, z, capped};
    ma = h;
    mb = (state == ST_MUL_Z) ? gv : zs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      method <= METH_RK4;
    end else begin
      state <= state_next;
      if (cfg_we) method <= method_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x <= '0; y <= '0; z <= '0;
      n <= '0;
      capped <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (in_ch.valid) begin
          {x, y, z} <= in_ch.data[158:63];
          h  <= {1'b0, in_ch.data[62:32]};
          hh <= {2'b0, in_ch.data[62:33]};
          xe <= in_ch.data[31:0];
          n  <= '0;
        end
        ST_CHECK: begin
          capped <= cont ? 1'b0 : (x <= xe);
          ys <= y; zs <= z; stage <= 2'd0;
          xr <= sat36(36'(x) + 36'(hh));
          sy <= '0; sz <= '0; wait_cnt <= '0; div_cnt <= '0;
        end
        ST_G: begin
          gv <= sat36(36'(xs) + 36'(ys) * 36'sd2 - 36'(zs) * 36'sd3);
          wait_cnt <= '0;
        end
        ST_MUL_Y: begin
          wait_cnt <= (wait_cnt == 2'd2) ? 2'd0 : wait_cnt + 2'd1;
          if (wait_cnt == 2'd2) ky <= mp;
        end
        ST_MUL_Z: begin
          wait_cnt <= (wait_cnt == 2'd2) ? 2'd0 : wait_cnt + 2'd1;
          if (wait_cnt == 2'd2) kz <= mp;
        end
        ST_STAGE: begin
          if (stage == 2'd1 || stage == 2'd2) begin
            sy <= sy + 36'(ky) * 36'sd2; sz <= sz + 36'(kz) * 36'sd2;
          end else begin
            sy <= sy + 36'(ky); sz <= sz + 36'(kz);
          end
          if (stage == 2'd2) begin
            ys <= sat36(36'(y) + 36'(ky)); zs <= sat36(36'(z) + 36'(kz));
          end else begin
            ys <= sat36(36'(y) + 36'(ky >>> 1)); zs <= sat36(36'(z) + 36'(kz >>> 1));
          end
          if (method == METH_RK4) begin
            // hold stage slopes in the accumulators
          end else if (method == METH_MID && stage == 2'd1) begin
            dy <= 36'(ky); dz <= 36'(kz);
          end else if (method != METH_MID) begin
            dy <= 36'(ky); dz <= 36'(kz);
          end
          stage <= stage + 2'd1;
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 3'd1;
          case (div_cnt[1:0])
            2'd0: dn <= 37'(dsel) + 37'sd3;
            2'd1: begin
              dqa <= (dn >>> 19) * DIV_HI;
              dm  <= {{2{dn[36]}}, dn[36:19], 1'b0} + {2'b0, dn[18:0]};
            end
            2'd2: dq <= dqa + 37'(dprod >>> 24);
            default: if (div_cnt[2]) dz <= dfix[35:0]; else dy <= dfix[35:0];
          endcase
        end
        ST_UPD: begin
          y <= sat36(36'(y) + dy);
          z <= sat36(36'(z) + dz);
          x <= sat36(36'(x) + 36'(h));
          n <= n + STEP_W'(1);
        end
        default: ;
      endcase
    end
  end

  property p_busy_not_ready;
    @(posedge clk) disable iff (rst) (state != ST_IDLE) |-> !in_ch.ready;
  endproperty
  a_busy: assert property (p_busy_not_ready) else $error("ready while busy");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    n <= STEP_W'(MAX_STEPS)) else $error("step count beyond limit");

  a_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_ch.ready) |=> (state == ST_DONE && $stable(x)))
    else $error("result dropped");
endmodule

### test/ode_pair_integrator_top_test.sv
// Self-checking testbench for ode_pair_integrator_top: directed table, then random requests
// under each integration method and several handshake idling mixes.
// Depends on opi_pkg, opi_if and the integrator RTL.
`timescale 1ns / 1ps

module ode_pair_integrator_top_test;
  import opi_pkg::*;

  // Request and result words, fields in the order the block expects them.
  typedef struct packed {
    q_t          start_x;
    q_t          start_y;
    q_t          start_z;
    logic [30:0] step_size;
    q_t          end_x;
  } ode_req_t;

  typedef struct packed {
    q_t   final_x;
    q_t   final_y;
    q_t   final_z;
    logic steps_capped;
  } ode_res_t;

  // One row of the directed table: method to run under, the request, and an
  // expected result only where it is obvious by inspection.
  typedef struct {
    method_t  meth;
    ode_req_t req;
    bit       pinned;
    ode_res_t res;
  } vec_row_t;

  localparam int IDLE_LIMIT = 1000000;
  localparam q_t ONE        = 32'sh01000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_data = 2'd0;

  opi_if #(.word_t(ode_req_t)) req_ch ();
  opi_if #(.word_t(ode_res_t)) res_ch ();

  ode_pair_integrator_top DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (req_ch),
    .out_ch   (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the method register, plus scoreboard state.
  method_t  cur_method = METH_RK4;
  ode_res_t final_points[$];
  bit       pin_next = 1'b0;
  ode_res_t pin_res;
  int       err_count = 0;
  int       words_in = 0;
  int       words_out = 0;
  int       capped_seen = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       idle_cycles = 0;

  // ---------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------
  function automatic q_t sat_q(longint v);
    if (v > 64'sd2147483647) return Q_MAX;
    if (v < -64'sd2147483648) return Q_MIN;
    return q_t'(v);
  endfunction

  // Product rounds half up, then saturates.
  function automatic q_t mul_q(q_t a, q_t b);
    longint p;
    p = longint'(a) * longint'(b) + (64'sd1 <<< (FRAC_BITS - 1));
    return sat_q(p >>> FRAC_BITS);
  endfunction

  function automatic q_t add_q(q_t a, q_t b);
    return sat_q(longint'(a) + longint'(b));
  endfunction

  function automatic q_t slope_z(q_t x, q_t y, q_t z);
    return sat_q(longint'(x) + 2 * longint'(y) - 3 * longint'(z));
  endfunction

  // Divide by six, nearest, ties upward.
  function automatic longint div6_nearest(longint s);
    longint n, q;
    n = s + 3;
    q = n / 6;
    if (n % 6 != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic ode_res_t integrate(ode_req_t r, method_t m);
    q_t x, y, z, h, hh, xe, xm, ny, nz;
    q_t ky1, kz1, ky2, kz2, ky3, kz3, ky4, kz4, y2, z2, y3, z3, y4, z4;
    longint sy, sz;
    int n;
    ode_res_t o;
    x = r.start_x; y = r.start_y; z = r.start_z; xe = r.end_x;
    h = q_t'({1'b0, r.step_size});
    hh = h >>> 1;
    n = 0;
    while (x <= xe && n < MAX_STEPS) begin
      ky1 = mul_q(h, z);
      kz1 = mul_q(h, slope_z(x, y, z));
      if (m == METH_RK4 || m == METH_MID) begin
        xm = add_q(x, hh);
        y2 = add_q(y, ky1 >>> 1);
        z2 = add_q(z, kz1 >>> 1);
        ky2 = mul_q(h, z2);
        kz2 = mul_q(h, slope_z(xm, y2, z2));
        if (m == METH_MID) begin
          ny = add_q(y, ky2);
          nz = add_q(z, kz2);
        end else begin
          y3 = add_q(y, ky2 >>> 1);
          z3 = add_q(z, kz2 >>> 1);
          ky3 = mul_q(h, z3);
          kz3 = mul_q(h, slope_z(xm, y3, z3));
          y4 = add_q(y, ky3);
          z4 = add_q(z, kz3);
          ky4 = mul_q(h, z4);
          kz4 = mul_q(h, slope_z(add_q(x, h), y4, z4));
          sy = longint'(ky1) + 2 * longint'(ky2) + 2 * longint'(ky3) + longint'(ky4);
          sz = longint'(kz1) + 2 * longint'(kz2) + 2 * longint'(kz3) + longint'(kz4);
          ny = sat_q(longint'(y) + div6_nearest(sy));
          nz = sat_q(longint'(z) + div6_nearest(sz));
        end
      end else begin
        // forward Euler; unused code 3 falls here too
        ny = add_q(y, ky1);
        nz = add_q(z, kz1);
      end
      y = ny;
      z = nz;
      x = add_q(x, h);
      n++;
    end
    o.final_x = x;
    o.final_y = y;
    o.final_z = z;
    o.steps_capped = (x <= xe);
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Monitors: predict on every accepted request, check every result
  // ---------------------------------------------------------------------
  task automatic report(string what, q_t got, q_t want);
    $display("MISMATCH t=%0t result %0d %s: got %h want %h", $realtime, words_out, what,
             got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      final_points.push_back(pin_next ? pin_res : integrate(req_ch.data, cur_method));
      words_in++;
    end
  end

  always @(posedge clk) begin
    ode_res_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      words_out++;
      if (got.steps_capped) capped_seen++;
      if (final_points.size() == 0) begin
        report("unexpected word", got.final_x, '0);
      end else begin
        want = final_points.pop_front();
        if (got.final_x !== want.final_x) report("final_x", got.final_x, want.final_x);
        if (got.final_y !== want.final_y) report("final_y", got.final_y, want.final_y);
        if (got.final_z !== want.final_z) report("final_z", got.final_z, want.final_z);
        if (got.steps_capped !== want.steps_capped)
          report("steps_capped", q_t'(got.steps_capped), q_t'(want.steps_capped));
      end
    end
  end

  // Receiver stall pattern: redrawn every cycle.
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: count cycles with no word moving on either channel.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("ode_pair_integrator_top_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  // Hold until every expected result is back, then let the block settle.
  task automatic drain();
    @(posedge clk);
    while (final_points.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_method(method_t m);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_method = m;
  endtask

  // Present one request word; optionally idle first. Returns at its acceptance edge.
  task automatic send_req(ode_req_t r);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Random request. Most are well-formed runs of a few dozen steps at most;
  // the rest are full-range words that stop after one step or none.
  function automatic ode_req_t rand_req();
    ode_req_t r;
    longint xe;
    int k;
    r.start_y = ($urandom_range(3) == 0) ? q_t'($urandom) : q_t'($urandom) >>> 5;
    r.start_z = ($urandom_range(3) == 0) ? q_t'($urandom) : q_t'($urandom) >>> 5;
    case ($urandom_range(9))
      0: begin
        // start beyond end
        r.start_x = q_t'($urandom);
        r.step_size = 31'($urandom);
        r.end_x = (r.start_x == Q_MIN) ? Q_MIN : r.start_x - q_t'($urandom_range(1, 1000000));
        if (r.end_x >= r.start_x) r.end_x = Q_MIN;
        if (r.start_x == Q_MIN) r.start_x = 0;
      end
      1: begin
        // full-range word, exactly one step (x always passes end after it)
        r.start_x = q_t'($urandom);
        if (r.start_x == Q_MAX) r.start_x = 0;
        r.step_size = 31'($urandom) | 31'd1;
        r.end_x = r.start_x;
      end
      default: begin
        r.start_x = q_t'($urandom) >>> 1;
        case ($urandom_range(2))
          0: r.step_size = 31'($urandom_range(1, 1 << 20));
          1: r.step_size = 31'($urandom_range(1, 1 << 24));
          default: r.step_size = 31'($urandom_range(1, 1 << 27));
        endcase
        k = $urandom_range(0, 30);
        xe = longint'(r.start_x) + longint'(k) * longint'(r.step_size)
             + longint'($urandom_range(0, r.step_size - 1));
        if (xe >= 64'sd2147483647) xe = 64'sd2147483646;
        r.end_x = q_t'(xe);
      end
    endcase
    return r;
  endfunction

  function automatic ode_req_t mk(q_t x, q_t y, q_t z, logic [30:0] h, q_t xe);
    ode_req_t r;
    r.start_x = x; r.start_y = y; r.start_z = z; r.step_size = h; r.end_x = xe;
    return r;
  endfunction

  function automatic ode_res_t pin(q_t x, q_t y, q_t z, logic c);
    ode_res_t o;
    o.final_x = x; o.final_y = y; o.final_z = z; o.steps_capped = c;
    return o;
  endfunction

  vec_row_t vecs[$];

  task automatic build_table();
    vec_row_t v;
    // start beyond end at the extremes: start point comes back untouched
    v = '{METH_RK4, mk(Q_MAX, Q_MIN, Q_MAX, '1, Q_MIN), 1, pin(Q_MAX, Q_MIN, Q_MAX, 0)};
    vecs.push_back(v);
    v = '{METH_RK4, mk(0, 0, 0, 31'd1, -1), 1, pin(0, 0, 0, 0)};
    vecs.push_back(v);
    v = '{METH_RK4, mk(0, ONE, 0, 31'(ONE >>> 3), ONE), 0, '0};
    vecs.push_back(v);
    v = '{METH_RK4, mk(0, Q_MAX, Q_MIN, 31'(ONE), 0), 0, '0};
    vecs.push_back(v);
    v = '{METH_RK4, mk(Q_MIN, Q_MIN, Q_MAX, '1, Q_MIN), 0, '0};
    vecs.push_back(v);
    v = '{METH_RK4, mk(-ONE, -ONE, ONE, 31'(ONE >>> 4), -(ONE >>> 1)), 0, '0};
    vecs.push_back(v);
    v = '{METH_MID, mk(0, ONE, 0, 31'(ONE >>> 3), ONE), 0, '0};
    vecs.push_back(v);
    v = '{METH_MID, mk(0, Q_MIN, Q_MAX, 31'(ONE), 0), 0, '0};
    vecs.push_back(v);
    v = '{METH_MID, mk(5, 0, 0, 31'd1, 4), 1, pin(5, 0, 0, 0)};
    vecs.push_back(v);
    v = '{METH_EUL, mk(0, ONE, 0, 31'(ONE >>> 3), ONE), 0, '0};
    vecs.push_back(v);
    // zero step: x never moves, every increment rounds to zero, count caps
    v = '{METH_EUL, mk(5 * ONE, ONE, -2 * ONE, 31'd0, 6 * ONE), 1,
          pin(5 * ONE, ONE, -2 * ONE, 1)};
    vecs.push_back(v);
    // x saturates and end is the largest value: count caps
    v = '{METH_EUL, mk(Q_MAX - 100, 0, 0, 31'(ONE), Q_MAX), 0, '0};
    vecs.push_back(v);
    v = '{METH_EUL, mk(Q_MAX, Q_MAX, Q_MIN, '1, Q_MAX), 0, '0};
    vecs.push_back(v);
    // unused method code runs as Euler
    v = '{METH_EUL3, mk(0, ONE, 0, 31'(ONE >>> 3), ONE), 0, '0};
    vecs.push_back(v);
    v = '{METH_EUL3, mk(Q_MIN, Q_MAX, Q_MIN, 31'(ONE), Q_MIN), 0, '0};
    vecs.push_back(v);
  endtask

  // Random phase: n requests, with one full drain partway through if asked.
  task automatic random_phase(method_t m, int snd, int rcv, int n, bit hold_mid);
    set_method(m);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (final_points.size() != 0) @(posedge clk);
      end
      send_req(rand_req());
    end
    req_ch.valid <= 1'b0;
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    build_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: no idling, pinned rows take their typed result.
    foreach (vecs[i]) begin
      if (vecs[i].meth != cur_method) begin
        req_ch.valid <= 1'b0;
        set_method(vecs[i].meth);
      end
      pin_next <= vecs[i].pinned;
      pin_res  <= vecs[i].res;
      send_req(vecs[i].req);
    end
    req_ch.valid <= 1'b0;
    pin_next <= 1'b0;

    random_phase(METH_RK4,   0,  0, 75, 1'b1);
    random_phase(METH_MID,  64,  0, 75, 1'b0);
    random_phase(METH_EUL,   0, 64, 75, 1'b0);
    random_phase(METH_EUL3, 34, 34, 40, 1'b0);
    random_phase(METH_RK4,  34, 34, 35, 1'b0);

    drain();
    repeat (200) @(posedge clk);

    $display("run covered %0d requests and %0d results (%0d step-capped)", words_in,
             words_out, capped_seen);
    $display("all four method codes, idling mixes, extremes and stop conditions applied");
    if (err_count == 0 && final_points.size() == 0) begin
      $display("ode_pair_integrator_top_test: done, clean");
    end else begin
      $display("ode_pair_integrator_top_test: done, errors");
    end
    $finish;
  end

endmodule
